// ===== hw/rtl/ocf_pkg.sv =====
// Shared widths and register indexes for the octree enclosing cube finder.
package ocf_pkg;

    localparam int COORD_W   = 48;                  // Q26.22 coordinates and origins
    localparam int SCALE_W   = 32;                  // normalization factor
    localparam int DIFF_W    = COORD_W + 1;         // coord - origin
    localparam int HI_W      = COORD_W - SCALE_W;   // upper slice of the difference
    localparam int IDX_W     = 23;                  // row / col / height
    localparam int LVL_W     = 5;                   // level
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_SCALE_X  = 3'd3,
        CFG_SCALE_Y  = 3'd4,
        CFG_SCALE_Z  = 3'd5
    } t_cfg_idx;

endpackage

// ===== hw/rtl/ocf_norm.sv =====
// One-axis normalizer: (coord - origin) * scale / 2^32, three register stages.
module ocf_norm import ocf_pkg::*; #(
    parameter int LEVELS = 24
) (
    input  logic                      i_clk,
    input  logic signed [COORD_W-1:0] i_coord,
    input  logic signed [COORD_W-1:0] i_origin,
    input  logic        [SCALE_W-1:0] i_scale,
    output logic        [LEVELS-1:0]  o_n,
    output logic                      o_ok
);

    logic [DIFF_W-1:0]          r_d;
    logic                       r_neg;
    logic [2*SCALE_W-1:0]       r_plo;
    logic [HI_W+SCALE_W-1:0]    r_phi;
    logic [LEVELS-1:0]          r_n;
    logic                       r_ok;

    logic [DIFF_W-1:0]          n_d;
    logic [DIFF_W-1:0]          n_v;
    logic                       n_zero_scale;

    assign n_d = {i_coord[COORD_W-1], i_coord} - {i_origin[COORD_W-1], i_origin};

    // floor(d*s/2^32) = hi*s + floor(lo*s/2^32) exactly, for d >= 0
    assign n_v = {1'b0, r_phi} + {{(DIFF_W-SCALE_W){1'b0}}, r_plo[2*SCALE_W-1:SCALE_W]};
    assign n_zero_scale = (i_scale == '0);

    always_ff @(posedge i_clk) begin
        r_d   <= n_d;
        r_neg <= r_d[DIFF_W-1];
        r_plo <= r_d[SCALE_W-1:0] * i_scale;
        r_phi <= r_d[COORD_W-1:SCALE_W] * i_scale;
        if (n_zero_scale) begin
            r_n  <= '0;
            r_ok <= 1'b1;
        end else begin
            r_n  <= n_v[LEVELS-1:0];
            r_ok <= !r_neg && (n_v[DIFF_W-1:LEVELS] == '0);
        end
    end

    assign o_n  = r_n;
    assign o_ok = r_ok;

endmodule

// ===== hw/rtl/octree_enclosing_cube_finder.sv =====
// Top level: smallest enclosing cell of a box in a halving cube pyramid.
//
// One box is taken per clock whenever start is high and busy is low; busy is
// high only while reset is asserted. The result comes out exactly five cycles
// after the box is taken, on the o_ ports for a single cycle marked by
// o_strobe, and must be captured then since there is no backpressure. The
// latency is set by the pipeline: input register, subtract, the 32x32 and
// 16x32 multiplies, the partial-product add with range check, and the level
// search with index shift into the result register. Configuration writes take
// effect at once and must only be made while no box is in flight.
module octree_enclosing_cube_finder import ocf_pkg::*; #(
    parameter int LEVELS = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [COORD_W-1:0]        i_cfg_data,
    input  logic signed [COORD_W-1:0] i_min_x,
    input  logic signed [COORD_W-1:0] i_min_y,
    input  logic signed [COORD_W-1:0] i_min_z,
    input  logic signed [COORD_W-1:0] i_max_x,
    input  logic signed [COORD_W-1:0] i_max_y,
    input  logic signed [COORD_W-1:0] i_max_z,
    output logic                      o_strobe,
    output logic [LVL_W-1:0]          o_level,
    output logic [IDX_W-1:0]          o_row,
    output logic [IDX_W-1:0]          o_col,
    output logic [IDX_W-1:0]          o_height,
    output logic                      o_out_of_range
);

    localparam int LW    = $clog2(LEVELS);
    localparam int SW    = $clog2(LEVELS + 1);
    localparam int NSTG  = 4;   // input register + three normalizer stages

    // configuration
    logic signed [COORD_W-1:0] r_org_x, r_org_y, r_org_z;
    logic        [SCALE_W-1:0] r_scl_x, r_scl_y, r_scl_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_z <= '0;
            r_scl_x <= '0;
            r_scl_y <= '0;
            r_scl_z <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORIGIN_X: r_org_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_org_y <= i_cfg_data;
                CFG_ORIGIN_Z: r_org_z <= i_cfg_data;
                CFG_SCALE_X:  r_scl_x <= i_cfg_data[SCALE_W-1:0];
                CFG_SCALE_Y:  r_scl_y <= i_cfg_data[SCALE_W-1:0];
                CFG_SCALE_Z:  r_scl_z <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // input beat
    logic                      accept;
    logic signed [COORD_W-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic [NSTG-1:0]           r_vld;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ax <= i_min_x;
            r_ay <= i_min_y;
            r_az <= i_min_z;
            r_bx <= i_max_x;
            r_by <= i_max_y;
            r_bz <= i_max_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], accept};
        end
    end

    // six normalizers, one per corner and axis
    logic [LEVELS-1:0] nax, nay, naz, nbx, nby, nbz;
    logic              okax, okay, okaz, okbx, okby, okbz;

    ocf_norm #(.LEVELS(LEVELS)) u_norm_ax (.i_clk(i_clk), .i_coord(r_ax), .i_origin(r_org_x),
        .i_scale(r_scl_x), .o_n(nax), .o_ok(okax));
    ocf_norm #(.LEVELS(LEVELS)) u_norm_ay (.i_clk(i_clk), .i_coord(r_ay), .i_origin(r_org_y),
        .i_scale(r_scl_y), .o_n(nay), .o_ok(okay));
    ocf_norm #(.LEVELS(LEVELS)) u_norm_az (.i_clk(i_clk), .i_coord(r_az), .i_origin(r_org_z),
        .i_scale(r_scl_z), .o_n(naz), .o_ok(okaz));
    ocf_norm #(.LEVELS(LEVELS)) u_norm_bx (.i_clk(i_clk), .i_coord(r_bx), .i_origin(r_org_x),
        .i_scale(r_scl_x), .o_n(nbx), .o_ok(okbx));
    ocf_norm #(.LEVELS(LEVELS)) u_norm_by (.i_clk(i_clk), .i_coord(r_by), .i_origin(r_org_y),
        .i_scale(r_scl_y), .o_n(nby), .o_ok(okby));
    ocf_norm #(.LEVELS(LEVELS)) u_norm_bz (.i_clk(i_clk), .i_coord(r_bz), .i_origin(r_org_z),
        .i_scale(r_scl_z), .o_n(nbz), .o_ok(okbz));

    // common prefix length, capped at LEVELS-1
    logic [LEVELS-1:0] diff;
    logic [LW-1:0]     top_bit;
    logic [LW-1:0]     lvl;
    logic [SW-1:0]     sh;
    logic [LEVELS-1:0] cx, cy, cz;
    logic              all_ok;

    assign diff = (nax ^ nbx) | (nay ^ nby) | (naz ^ nbz);

    always_comb begin
        top_bit = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (diff[i]) top_bit = LW'(i);
        end
    end

    assign lvl    = LW'(LEVELS - 1) - top_bit;
    assign sh     = SW'(LEVELS) - SW'(lvl);
    assign cx     = nax >> sh;
    assign cy     = nay >> sh;
    assign cz     = naz >> sh;
    assign all_ok = okax && okay && okaz && okbx && okby && okbz;

    // result beat
    logic              r_strobe;
    logic [LVL_W-1:0]  r_level;
    logic [IDX_W-1:0]  r_row, r_col, r_height;
    logic              r_oor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vld[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (all_ok) begin
            r_level  <= LVL_W'(lvl);
            r_row    <= IDX_W'(cy);
            r_col    <= IDX_W'(cx);
            r_height <= IDX_W'(cz);
            r_oor    <= 1'b0;
        end else begin
            r_level  <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_height <= '0;
            r_oor    <= 1'b1;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_level        = r_level;
    assign o_row          = r_row;
    assign o_col          = r_col;
    assign o_height       = r_height;
    assign o_out_of_range = r_oor;

    // every result beat traces back to an accepted box
    a_strobe_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, NSTG + 1))
        else $error("result beat without matching input beat");

    // the cell indices fit within as many bits as the reported level
    a_idx_fits_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_row >> o_level) == '0) && ((o_col >> o_level) == '0)
                     && ((o_height >> o_level) == '0))
        else $error("cell index wider than level");

    a_level_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (32'(o_level) < LEVELS))
        else $error("level beyond deepest level");

endmodule
